### rtl/core/touch_axis_median_normalizer_defines.svh
// Assertion macros for the touch axis median normalizer checker.
// Included by the checker file; needs nothing else.
`ifndef TOUCH_AXIS_MEDIAN_NORMALIZER_DEFINES_SVH
`define TOUCH_AXIS_MEDIAN_NORMALIZER_DEFINES_SVH

// Concurrent check, muted while reset is asserted.
`define TAMN_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tamn check failed");

// Concurrent check that also holds across reset.
`define TAMN_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("tamn check failed");

`endif

### rtl/core/tamn_pkg.sv
// Shared types and constants of the touch axis median normalizer.
// Used by every module of the block; depends on nothing.
package tamn_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int POS_BITS    = 16;
  localparam int FRAC_BITS   = 12;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  localparam logic [SAMPLE_BITS-1:0] X_LOW_RST  = SAMPLE_BITS'(850);
  localparam logic [SAMPLE_BITS-1:0] X_HIGH_RST = SAMPLE_BITS'(2750);
  localparam logic [SAMPLE_BITS-1:0] Y_LOW_RST  = SAMPLE_BITS'(1700);
  localparam logic [SAMPLE_BITS-1:0] Y_HIGH_RST = SAMPLE_BITS'(2500);
  localparam logic                   CROSS_ADD_RST = 1'b1;

  localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_X_LOW     = 3'd0,
    REG_X_HIGH    = 3'd1,
    REG_Y_LOW     = 3'd2,
    REG_Y_HIGH    = 3'd3,
    REG_CROSS_ADD = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SCAN,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SUM,
    B_DIV,
    B_FIN
  } back_state_t;

  typedef struct packed {
    logic                   axis;
    logic [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                       axis_out;
    logic signed [POS_BITS-1:0] position;
    logic                       saturated;
  } out_item_t;

  typedef struct packed {
    logic                   axis;
    logic [SAMPLE_BITS-1:0] median;
  } med_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] x_low;
    logic [SAMPLE_BITS-1:0] x_high;
    logic [SAMPLE_BITS-1:0] y_low;
    logic [SAMPLE_BITS-1:0] y_high;
    logic                   cross_add;
  } cfg_t;

endpackage

### rtl/core/tamn_front.sv
// Front end: takes samples, keeps the per-axis windows and finds the upper median.
// Depends on tamn_pkg; feeds tamn_fifo.
module tamn_front #(
  parameter int WINDOW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  tamn_pkg::in_item_t in_item,
  output logic               q_push,
  output tamn_pkg::med_item_t q_data,
  input  logic               q_full
);
  import tamn_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int RANK_W = $clog2(WINDOW + 1);
  localparam logic [RANK_W-1:0] MED_RANK = RANK_W'(WINDOW / 2);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  front_state_t fs_r, fs_nxt;
  logic [SAMPLE_BITS-1:0] win_r [2][WINDOW];
  logic [SLOT_W-1:0]      slot_r [2];
  logic [SLOT_W-1:0]      cand_r, cand_nxt;
  logic                   axis_r, axis_nxt;
  logic [SAMPLE_BITS-1:0] med_r, med_nxt;
  logic                   accept;
  logic [SAMPLE_BITS-1:0] cand_val;
  logic [WINDOW-1:0]      below;
  logic [RANK_W-1:0]      rank;

  assign in_full = (fs_r != F_IDLE);
  assign accept  = in_push && !in_full;
  assign cand_val = win_r[axis_r][cand_r];

  // Stable rank: smaller entries, plus equal ones at a lower slot.
  always_comb begin
    for (int j = 0; j < WINDOW; j++) begin
      below[j] = (win_r[axis_r][j] < cand_val) ||
                 ((win_r[axis_r][j] == cand_val) && (SLOT_W'(j) < cand_r));
    end
    rank = RANK_W'($countones(below));
  end

  always_comb begin
    fs_nxt   = fs_r;
    cand_nxt = cand_r;
    axis_nxt = axis_r;
    med_nxt  = med_r;
    q_push   = 1'b0;
    unique case (fs_r)
      F_IDLE: begin
        if (accept) begin
          axis_nxt = in_item.axis;
          cand_nxt = '0;
          fs_nxt   = F_SCAN;
        end
      end
      F_SCAN: begin
        if (rank == MED_RANK) begin
          med_nxt = cand_val;
          fs_nxt  = F_PUSH;
        end else if (cand_r == LAST_SLOT) begin
          fs_nxt = F_PUSH;
        end else begin
          cand_nxt = cand_r + 1'b1;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push = 1'b1;
          fs_nxt = F_IDLE;
        end
      end
      default: fs_nxt = F_IDLE;
    endcase
  end

  assign q_data = '{axis: axis_r, median: med_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r   <= F_IDLE;
      cand_r <= '0;
      axis_r <= 1'b0;
      med_r  <= '0;
      for (int a = 0; a < 2; a++) begin
        slot_r[a] <= '0;
        for (int i = 0; i < WINDOW; i++) begin
          win_r[a][i] <= '0;
        end
      end
    end else begin
      fs_r   <= fs_nxt;
      cand_r <= cand_nxt;
      axis_r <= axis_nxt;
      med_r  <= med_nxt;
      if (accept) begin
        win_r[in_item.axis][slot_r[in_item.axis]] <= in_item.sample;
        slot_r[in_item.axis] <= (slot_r[in_item.axis] == LAST_SLOT) ? '0 :
                                slot_r[in_item.axis] + 1'b1;
      end
    end
  end

endmodule

### rtl/core/tamn_fifo.sv
// Two-entry queue of medians between the front and back ends.
// Depends on tamn_pkg.
module tamn_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tamn_pkg::med_item_t push_data,
  output logic                full,
  input  logic                pop,
  output tamn_pkg::med_item_t pop_data,
  output logic                empty
);
  import tamn_pkg::*;

  med_item_t   mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/core/tamn_back.sv
// Back end: maps a median to a signed Q4.12 position with a bit-serial divider.
// Depends on tamn_pkg; drains tamn_fifo and holds the result register.
module tamn_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tamn_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  tamn_pkg::med_item_t q_data,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output tamn_pkg::out_item_t out_item
);
  import tamn_pkg::*;

  localparam int PROD_W = POS_BITS + SAMPLE_BITS + 1;
  localparam int NUM_W  = POS_BITS + SAMPLE_BITS + 3;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] Q_POS_LIM = NUM_W'(2 ** (POS_BITS - 1) - 1);
  localparam logic [NUM_W-1:0] Q_NEG_LIM = NUM_W'(2 ** (POS_BITS - 1));

  back_state_t bs_r, bs_nxt;
  logic                          axis_r, axis_nxt;
  logic [SAMPLE_BITS-1:0]        med_r, med_nxt;
  logic signed [SAMPLE_BITS:0]   diff_r, diff_nxt;
  logic signed [SAMPLE_BITS:0]   span_r, span_nxt;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic                          special_r, special_nxt;
  logic                          neg_r, neg_nxt;
  logic [NUM_W-1:0]              quo_r, quo_nxt;
  logic [SAMPLE_BITS-1:0]        rem_r, rem_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic signed [POS_BITS-1:0]    last_x_r, last_x_nxt;
  logic                          out_valid_r, out_valid_nxt;
  out_item_t                     out_item_r, out_item_nxt;

  logic [SAMPLE_BITS-1:0]        low_sel, high_sel;
  logic signed [SAMPLE_BITS:0]   span_c;
  logic signed [POS_BITS-1:0]    lx;
  logic signed [NUM_W-1:0]       num_c;
  logic [SAMPLE_BITS:0]          trial;
  logic                          fits;
  logic signed [POS_BITS-1:0]    pos_c;
  logic                          sat_c;

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    low_sel  = axis_r ? cfg.y_low  : cfg.x_low;
    high_sel = axis_r ? cfg.y_high : cfg.x_high;
    span_c   = $signed({1'b0, high_sel}) - $signed({1'b0, low_sel});
    lx       = (axis_r && cfg.cross_add) ? last_x_r : '0;
    num_c    = (NUM_W'(diff_r) <<< (FRAC_BITS + 1)) - (NUM_W'(span_r) <<< FRAC_BITS) +
               NUM_W'(prod_r);
    trial    = {rem_r, quo_r[NUM_W-1]};
    fits     = (trial >= {1'b0, span_r[SAMPLE_BITS-1:0]});
    // Truncated quotient magnitude, then sign and clip.
    if (special_r) begin
      pos_c = diff_r[SAMPLE_BITS] ? POS_MIN : POS_MAX;
      sat_c = 1'b1;
    end else if (neg_r) begin
      sat_c = (quo_r > Q_NEG_LIM);
      pos_c = sat_c ? POS_MIN : -$signed(quo_r[POS_BITS-1:0]);
    end else begin
      sat_c = (quo_r > Q_POS_LIM);
      pos_c = sat_c ? POS_MAX : $signed(quo_r[POS_BITS-1:0]);
    end
  end

  always_comb begin
    bs_nxt        = bs_r;
    axis_nxt      = axis_r;
    med_nxt       = med_r;
    diff_nxt      = diff_r;
    span_nxt      = span_r;
    prod_nxt      = prod_r;
    special_nxt   = special_r;
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    last_x_nxt    = last_x_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;
    q_pop         = 1'b0;
    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    unique case (bs_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          axis_nxt = q_data.axis;
          med_nxt  = q_data.median;
          bs_nxt   = B_MUL;
        end
      end
      B_MUL: begin
        diff_nxt    = $signed({1'b0, med_r}) - $signed({1'b0, low_sel});
        span_nxt    = span_c;
        prod_nxt    = PROD_W'(lx) * PROD_W'(span_c);
        special_nxt = (span_c <= 0);
        bs_nxt      = (span_c <= 0) ? B_FIN : B_SUM;
      end
      B_SUM: begin
        neg_nxt = num_c[NUM_W-1];
        quo_nxt = num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);
        rem_nxt = '0;
        cnt_nxt = CNT_W'(NUM_W - 1);
        bs_nxt  = B_DIV;
      end
      B_DIV: begin
        // Restoring division, one quotient bit per cycle.
        rem_nxt = fits ? SAMPLE_BITS'(trial - {1'b0, span_r[SAMPLE_BITS-1:0]}) :
                         SAMPLE_BITS'(trial);
        quo_nxt = {quo_r[NUM_W-2:0], fits};
        if (cnt_r == '0) begin
          bs_nxt = B_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      B_FIN: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{axis_out: axis_r, position: pos_c, saturated: sat_c};
          if (!axis_r) begin
            last_x_nxt = pos_c;
          end
          bs_nxt = B_IDLE;
        end
      end
      default: bs_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r        <= B_IDLE;
      out_valid_r <= 1'b0;
      last_x_r    <= '0;
    end else begin
      bs_r        <= bs_nxt;
      out_valid_r <= out_valid_nxt;
      last_x_r    <= last_x_nxt;
    end
  end

  always_ff @(posedge clk) begin
    axis_r     <= axis_nxt;
    med_r      <= med_nxt;
    diff_r     <= diff_nxt;
    span_r     <= span_nxt;
    prod_r     <= prod_nxt;
    special_r  <= special_nxt;
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

### rtl/core/touch_axis_median_normalizer.sv
// Touchscreen axis filter: each 12-bit sample, tagged X or Y, replaces the oldest entry
// of that axis's WINDOW-deep window (zero after reset); the upper median of the window
// is mapped through the axis calibration to a signed Q4.12 position, with the last X
// position added into Y results when cross_add is set, and clipped with a flag. One
// result per sample, in order. The front end ranks one window slot at a time and waits
// while the median queue is full; the back end computes each result with its 31-step
// bit-serial divider. Neither side takes a new item before it is through with the last.
// A two-entry median queue and the result register let either side stall on its own.
// Registers at byte 0x00 x_low, 0x04 x_high, 0x08 y_low, 0x0C y_high, 0x10 cross_add;
// change them only while no sample is in flight.
module touch_axis_median_normalizer #(
  parameter int WINDOW = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  tamn_pkg::in_item_t                  in_item,
  output logic                                out_empty,
  input  logic                                out_pop,
  output tamn_pkg::out_item_t                 out_item,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tamn_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [tamn_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [tamn_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import tamn_pkg::*;

  cfg_t      cfg_r;
  reg_idx_t  reg_idx;
  logic      cfg_wr;
  logic      q_push, q_full, q_pop, q_empty;
  med_item_t q_wdata, q_rdata;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{x_low: X_LOW_RST, x_high: X_HIGH_RST, y_low: Y_LOW_RST,
                 y_high: Y_HIGH_RST, cross_add: CROSS_ADD_RST};
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_X_LOW:     cfg_r.x_low     <= cfg_pwdata[SAMPLE_BITS-1:0];
        REG_X_HIGH:    cfg_r.x_high    <= cfg_pwdata[SAMPLE_BITS-1:0];
        REG_Y_LOW:     cfg_r.y_low     <= cfg_pwdata[SAMPLE_BITS-1:0];
        REG_Y_HIGH:    cfg_r.y_high    <= cfg_pwdata[SAMPLE_BITS-1:0];
        REG_CROSS_ADD: cfg_r.cross_add <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_X_LOW:     cfg_prdata = CFG_DATA_W'(cfg_r.x_low);
      REG_X_HIGH:    cfg_prdata = CFG_DATA_W'(cfg_r.x_high);
      REG_Y_LOW:     cfg_prdata = CFG_DATA_W'(cfg_r.y_low);
      REG_Y_HIGH:    cfg_prdata = CFG_DATA_W'(cfg_r.y_high);
      REG_CROSS_ADD: cfg_prdata = CFG_DATA_W'(cfg_r.cross_add);
      default:       cfg_prdata = '0;
    endcase
  end

  tamn_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  tamn_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  tamn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

### rtl/core/tamn_checker.sv
// Port-level checks for the touch axis median normalizer, bound to the top level.
// Depends on tamn_pkg and touch_axis_median_normalizer_defines.svh.
`include "touch_axis_median_normalizer_defines.svh"

module tamn_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input tamn_pkg::out_item_t out_item,
  input logic                cfg_pready
);
  import tamn_pkg::*;

  // Result register must come up empty.
  `TAMN_ASSERT_ALWAYS(a_empty_after_reset, clk, !rst_n |=> out_empty)

  // Front end goes busy for the median scan after taking a sample.
  `TAMN_ASSERT(a_busy_after_accept, clk, rst_n, (in_push && !in_full) |=> in_full)

  // A waiting result holds until popped.
  `TAMN_ASSERT(a_result_held, clk, rst_n,
               (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))

  // The flag only ever comes with a clipped value.
  `TAMN_ASSERT(a_sat_at_rail, clk, rst_n,
               (!out_empty && out_item.saturated) |->
               (out_item.position == POS_MAX || out_item.position == POS_MIN))

  // Writes never wait.
  `TAMN_ASSERT(a_pready_high, clk, rst_n, cfg_pready)

endmodule

bind touch_axis_median_normalizer tamn_checker u_tamn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_push    (in_push),
  .in_full    (in_full),
  .out_empty  (out_empty),
  .out_pop    (out_pop),
  .out_item   (out_item),
  .cfg_pready (cfg_pready)
);

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for touch_axis_median_normalizer: directed table, then random phases.
// Predicts each result from its own windows and calibration; needs only tamn_pkg and the RTL.
module tb_top;
  import tamn_pkg::*;

  localparam int WIN = 8;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 100;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 64;
  localparam longint ONE_Q = longint'(1) << FRAC_BITS;
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;
  localparam int REG_SPARE_A = 5;
  localparam int REG_SPARE_B = 7;
  localparam logic [SAMPLE_BITS-1:0] ADC_MAX = '1;

  typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    int unsigned                idx;
    logic [CFG_DATA_W-1:0]      data;
    logic                       axis;
    logic [SAMPLE_BITS-1:0]     sample;
    bit                         typed;
    logic signed [POS_BITS-1:0] pos;
    logic                       sat;
  } stim_row_t;

  localparam int NUM_DIR = 24;

  logic                    clk;
  logic                    rst_n;
  logic                    in_push;
  logic                    in_full;
  in_item_t                in_item;
  logic                    out_empty;
  logic                    out_pop;
  out_item_t               out_item;
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [CFG_ADDR_W-1:0]   cfg_paddr;
  logic [CFG_DATA_W-1:0]   cfg_pwdata;
  logic [CFG_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;

  // Predictor state
  logic [SAMPLE_BITS-1:0]     win [2][WIN];
  logic [2:0]                 slot [2];
  logic [SAMPLE_BITS-1:0]     cal_low [2];
  logic [SAMPLE_BITS-1:0]     cal_high [2];
  logic                       cross_add;
  logic signed [POS_BITS-1:0] last_x;

  out_item_t pending_results [$];
  int        err_count;
  bit        idle_on;

  // Some saturating rows are typed in; the rest come from the predictor.
  stim_row_t dir_rows [NUM_DIR] = '{
    '{ROW_ITEM,  0,             32'h0,         AXIS_X, 12'd4095, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM,  0,             32'h0,         AXIS_Y, 12'd0,    1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM,  0,             32'h0,         AXIS_Y, 12'd4095, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_X_LOW,     32'hFFFF_FFFF, AXIS_X, 12'd0,    1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_X_HIGH,    32'hFFFF_F000, AXIS_X, 12'd0,    1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM,  0,             32'h0,         AXIS_X, 12'd0,    1'b1, POS_MIN, 1'b1},
    '{ROW_WRITE, REG_X_LOW,     32'h0,         AXIS_X, 12'd0,    1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM,  0,             32'h0,         AXIS_X, 12'd4095, 1'b1, POS_MAX, 1'b1},
    '{ROW_WRITE, REG_Y_LOW,     32'h0000_1FFE, AXIS_X, 12'd0,    1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_Y_HIGH,    32'h0000_0FFF, AXIS_X, 12'd0,    1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM,  0,             32'h0,         AXIS_Y, 12'd0,    1'b1, POS_MIN, 1'b1},
    '{ROW_WRITE, REG_CROSS_ADD, 32'hFFFF_FFFE, AXIS_X, 12'd0,    1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_X_HIGH,    32'h0000_0001, AXIS_X, 12'd0,    1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM,  0,             32'h0,         AXIS_X, 12'd4095, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM,  0,             32'h0,         AXIS_X, 12'd4095, 1'b1, POS_MAX, 1'b1},
    '{ROW_WRITE, REG_CROSS_ADD, 32'h0000_0001, AXIS_X, 12'd0,    1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_SPARE_A,   32'h0,         AXIS_X, 12'd0,    1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_SPARE_B,   32'hFFFF_FFFF, AXIS_X, 12'd0,    1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_Y_LOW,     32'h0,         AXIS_X, 12'd0,    1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_Y_HIGH,    32'h0000_0FFF, AXIS_X, 12'd0,    1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM,  0,             32'h0,         AXIS_Y, 12'd4095, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM,  0,             32'h0,         AXIS_X, 12'd0,    1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM,  0,             32'h0,         AXIS_Y, 12'd2048, 1'b0, 16'sd0, 1'b0},
    '{ROW_ITEM,  0,             32'h0,         AXIS_Y, 12'd1,    1'b0, 16'sd0, 1'b0}
  };

  touch_axis_median_normalizer #(.WINDOW(WIN)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_item     (in_item),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t normalize_sample(in_item_t it);
    logic [SAMPLE_BITS-1:0] srt [WIN];
    logic [SAMPLE_BITS-1:0] v;
    int j;
    longint med, low, high, span, lx, q;
    out_item_t r;
    win[it.axis][slot[it.axis]] = it.sample;
    slot[it.axis] = slot[it.axis] + 3'd1;
    for (int i = 0; i < WIN; i++) begin
      v = win[it.axis][i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    med = longint'(srt[WIN/2]);
    low = longint'(cal_low[it.axis]);
    high = longint'(cal_high[it.axis]);
    span = high - low;
    r.axis_out = it.axis;
    r.saturated = 1'b0;
    if (span <= 0) begin
      // No usable span: pin to a rail, ignore the X carry-over.
      r.position = (med >= low) ? POS_MAX : POS_MIN;
      r.saturated = 1'b1;
    end else begin
      lx = (it.axis == AXIS_Y && cross_add) ? longint'(last_x) : 0;
      q = (2 * ONE_Q * (med - low) - ONE_Q * span + lx * span) / span;
      if (q > POS_MAX) begin
        q = POS_MAX;
        r.saturated = 1'b1;
      end else if (q < POS_MIN) begin
        q = POS_MIN;
        r.saturated = 1'b1;
      end
      r.position = q[POS_BITS-1:0];
    end
    if (it.axis == AXIS_X) last_x = r.position;
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] reg_value(int unsigned idx);
    case (idx)
      REG_X_LOW:     return CFG_DATA_W'(cal_low[AXIS_X]);
      REG_X_HIGH:    return CFG_DATA_W'(cal_high[AXIS_X]);
      REG_Y_LOW:     return CFG_DATA_W'(cal_low[AXIS_Y]);
      REG_Y_HIGH:    return CFG_DATA_W'(cal_high[AXIS_Y]);
      default:       return CFG_DATA_W'(cross_add);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic apb_access(bit wr, int unsigned idx, logic [CFG_DATA_W-1:0] data,
                            output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= CFG_ADDR_W'(idx * 4);
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(int unsigned idx, logic [CFG_DATA_W-1:0] data);
    logic [CFG_DATA_W-1:0] rd;
    apb_access(1'b1, idx, data, rd);
    case (idx)
      REG_X_LOW:     cal_low[AXIS_X]  = data[SAMPLE_BITS-1:0];
      REG_X_HIGH:    cal_high[AXIS_X] = data[SAMPLE_BITS-1:0];
      REG_Y_LOW:     cal_low[AXIS_Y]  = data[SAMPLE_BITS-1:0];
      REG_Y_HIGH:    cal_high[AXIS_Y] = data[SAMPLE_BITS-1:0];
      REG_CROSS_ADD: cross_add        = data[0];
      default: ;
    endcase
    if (idx <= REG_CROSS_ADD) begin
      apb_access(1'b0, idx, '0, rd);
      if (rd !== reg_value(idx))
        report_mismatch($sformatf("reg %0d reads %h, want %h", idx, rd, reg_value(idx)));
    end
  endtask

  // Hold off until every item in flight has come out, then settle.
  task automatic drain_pipeline(int settle);
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t res;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full !== 1'b0);
    res = normalize_sample(it);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic pick_calibration(output logic [SAMPLE_BITS-1:0] lo, hi);
    case ($urandom_range(0, 9))
      0: begin
        lo = '0;
        hi = ADC_MAX;
      end
      1: begin
        lo = SAMPLE_BITS'($urandom_range(0, 4095));
        hi = lo;
      end
      2: begin
        lo = SAMPLE_BITS'($urandom_range(1, 4095));
        hi = SAMPLE_BITS'($urandom_range(0, lo - 1));
      end
      3: begin
        lo = SAMPLE_BITS'($urandom_range(0, 4094));
        hi = lo + 1'b1;
      end
      4: begin
        lo = ADC_MAX;
        hi = '0;
      end
      default: begin
        lo = SAMPLE_BITS'($urandom_range(0, 3000));
        hi = SAMPLE_BITS'($urandom_range(lo + 1, 4095));
      end
    endcase
  endtask

  // Result side: pop with random stall bursts, check each item popped.
  initial begin
    int stall;
    out_item_t want;
    stall = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_pop === 1'b1 && out_empty === 1'b0) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected item axis=%0d pos=%0d sat=%0d",
                                    out_item.axis_out, out_item.position, out_item.saturated));
        end else begin
          want = pending_results.pop_front();
          if (out_item.axis_out !== want.axis_out)
            report_mismatch($sformatf("axis_out %0d, want %0d",
                                      out_item.axis_out, want.axis_out));
          if (out_item.position !== want.position)
            report_mismatch($sformatf("position %0d, want %0d (axis %0d)",
                                      out_item.position, want.position, want.axis_out));
          if (out_item.saturated !== want.saturated)
            report_mismatch($sformatf("saturated %0d, want %0d (axis %0d pos %0d)",
                                      out_item.saturated, want.saturated,
                                      want.axis_out, want.position));
        end
      end
      if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 13) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no handshake of any kind moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_push === 1'b1 && in_full === 1'b0) || (out_pop === 1'b1 && out_empty === 1'b0)
          || (cfg_psel === 1'b1 && cfg_penable === 1'b1))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d items outstanding",
                 quiet, pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic                   cur_axis;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SAMPLE_BITS-1:0] smp;
    in_item_t               it;
    out_item_t              typed_res;

    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_item     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    err_count   = 0;
    idle_on     = 1'b1;
    cur_axis    = AXIS_X;
    for (int a = 0; a < 2; a++) begin
      slot[a] = '0;
      for (int i = 0; i < WIN; i++) win[a][i] = '0;
    end
    cal_low[AXIS_X]  = X_LOW_RST;
    cal_high[AXIS_X] = X_HIGH_RST;
    cal_low[AXIS_Y]  = Y_LOW_RST;
    cal_high[AXIS_Y] = Y_HIGH_RST;
    cross_add        = CROSS_ADD_RST;
    last_x           = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int r = 0; r < NUM_DIR; r++) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        drain_pipeline(4);
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        it = '{axis: dir_rows[r].axis, sample: dir_rows[r].sample};
        typed_res = '{axis_out: dir_rows[r].axis, position: dir_rows[r].pos,
                      saturated: dir_rows[r].sat};
        send_item(it, dir_rows[r].typed, typed_res);
      end
    end

    // Random phases, each under a fresh calibration; the last one runs at full rate.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_pipeline(4);
      idle_on = (ph == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      pick_calibration(lo, hi);
      write_reg(REG_X_LOW, {20'($urandom), lo});
      write_reg(REG_X_HIGH, {20'($urandom), hi});
      pick_calibration(lo, hi);
      write_reg(REG_Y_LOW, {20'($urandom), lo});
      write_reg(REG_Y_HIGH, {20'($urandom), hi});
      write_reg(REG_CROSS_ADD, {31'($urandom), 1'($urandom)});
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(REG_SPARE_A, REG_SPARE_B), $urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Stay on one axis for a while so the windows turn over.
        if ($urandom_range(0, 3) == 0) cur_axis = ~cur_axis;
        case ($urandom_range(0, 9))
          0:       smp = '0;
          1:       smp = ADC_MAX;
          2, 3:    smp = SAMPLE_BITS'($urandom);
          default: smp = SAMPLE_BITS'($urandom_range(cal_low[cur_axis], cal_high[cur_axis]));
        endcase
        send_item('{axis: cur_axis, sample: smp}, 1'b0, '0);
      end
    end

    drain_pipeline(TAIL_CYCLES);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### touch_axis_median_normalizer.f
+incdir+rtl/core
rtl/core/tamn_pkg.sv
rtl/core/tamn_front.sv
rtl/core/tamn_fifo.sv
rtl/core/tamn_back.sv
rtl/core/touch_axis_median_normalizer.sv
rtl/core/tamn_checker.sv
bench/tb_top.sv
